>>> rtl/priority_bucketed_sprite_list_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority bucketed sprite list unit
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_BUCKETED_SPRITE_LIST_UNIT_ASSERT_SVH
`define PRIORITY_BUCKETED_SPRITE_LIST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PBSL_ASSERT_IMP(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("pbsl assertion failed");

// Next-cycle implication.
`define PBSL_ASSERT_NXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("pbsl assertion failed");

`else

`define PBSL_ASSERT_IMP(label, clk, rst, ante, cons)
`define PBSL_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/pbsl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbsl_pkg
// Types and constants shared by the priority bucketed sprite list unit.
// ----------------------------------------------------------------------------
package pbsl_pkg;

    localparam int ATTR_W = 48;
    localparam int IDX_W  = 6;

    // Hidden entries carry 0x0200 in every attribute halfword.
    localparam logic [ATTR_W-1:0] FILLER_ATTRS = 48'h0200_0200_0200;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_VISIBLE = 2'd1,
        KIND_FILLER  = 2'd2
    } kind_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic REG_HIDE_TAIL = 1'b0;
    localparam logic REG_ALIGN_END = 1'b1;

endpackage

`default_nettype wire

>>> rtl/priority_bucketed_sprite_list_unit.sv
// Allocate: accepted in ST_IDLE, reply loaded into the output register from ST_ALLOC once
// there is room; no new request is taken until then, set by the bucket read-modify-write.
// Flush: buckets are scanned in order, the head of each nonempty bucket is read, then
// visible and hidden entries are emitted, and a final step empties all buckets.
// Reset clears the mode registers, counters, hide mark and bucket valid bits;
// the bucket and slot memories are not cleared and need no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// priority_bucketed_sprite_list_unit
// Queues sprite entries into priority buckets held as linked lists in a slot
// memory, and on a flush emits them in priority order followed by hidden
// entries chosen by the mode registers.
// ----------------------------------------------------------------------------
module priority_bucketed_sprite_list_unit #(
    parameter int SLOTS      = 64,
    parameter int PRIORITIES = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,

    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          opcode,
    input  wire  [7:0]                   priority_req,
    input  wire  [pbsl_pkg::ATTR_W-1:0]  sprite_attrs,

    output logic                         out_valid,
    input  wire                          out_ready,
    output pbsl_pkg::kind_t              kind,
    output logic                         accepted,
    output logic [pbsl_pkg::IDX_W-1:0]   slot,
    output logic [pbsl_pkg::IDX_W-1:0]   position,
    output logic [pbsl_pkg::IDX_W-1:0]   rank,
    output logic [pbsl_pkg::ATTR_W-1:0]  attrs_out,
    output logic                         last,

    input  wire                          cfg_we,
    input  wire                          cfg_index,
    input  wire                          cfg_wdata
);

    import pbsl_pkg::*;

    `include "priority_bucketed_sprite_list_unit_assert.svh"

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int PW = $clog2(PRIORITIES);

    localparam logic [CW-1:0] SLOTS_C   = CW'(SLOTS);
    localparam logic [PW-1:0] PRIO_LAST = PW'(PRIORITIES - 1);
    localparam logic [7:0]    PRIO_MAX8 = 8'(PRIORITIES - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ALLOC = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_HEAD  = 6'b001000,
        ST_WALK  = 6'b010000,
        ST_FILL  = 6'b100000
    } state_t;

    // Memories: bucket word is {head, tail}, slot word is {link, attrs}.
    logic [2*SW-1:0]        bkt_mem [PRIORITIES];
    logic [SW+ATTR_W-1:0]   slot_mem [SLOTS];
    logic [2*SW-1:0]        bkt_rdata_reg;
    logic [SW+ATTR_W-1:0]   slot_rdata_reg;

    logic                   bkt_we;
    logic [2*SW-1:0]        bkt_wdata;
    logic [PW-1:0]          bkt_raddr;
    logic                   slot_attr_we;
    logic                   slot_link_we;
    logic [SW-1:0]          slot_waddr;
    logic [ATTR_W-1:0]      slot_wattrs;
    logic [SW-1:0]          slot_wlink;
    logic [SW-1:0]          slot_raddr;

    // Control state.
    state_t                 state_reg, state_next;
    logic [CW-1:0]          used_count_reg, used_count_next;
    logic [CW-1:0]          hide_mark_reg, hide_mark_next;
    logic                   hide_tail_mode_reg, align_end_mode_reg;
    logic [PRIORITIES-1:0]  bucket_valid_reg, bucket_valid_next;
    logic [PW-1:0]          bidx_reg, bidx_next;
    logic [CW-1:0]          rank_reg, rank_next;
    logic [CW-1:0]          fill_i_reg, fill_i_next;
    logic [CW-1:0]          fill_hi_reg, fill_hi_next;
    logic                   no_fill_reg, no_fill_next;
    logic                   out_valid_reg, out_valid_next;

    // Payload state.
    logic [PW-1:0]          alloc_p_reg;
    logic [SW-1:0]          alloc_s_reg;
    logic                   alloc_full_reg;
    logic [ATTR_W-1:0]      alloc_attrs_reg;
    logic [SW-1:0]          cur_reg, cur_next;
    logic [SW-1:0]          tail_reg, tail_next;
    kind_t                  kind_reg, kind_next;
    logic                   accepted_reg, accepted_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [IDX_W-1:0]       position_reg, position_next;
    logic [IDX_W-1:0]       rank_out_reg, rank_out_next;
    logic [ATTR_W-1:0]      attrs_reg, attrs_next;
    logic                   last_reg, last_next;

    logic                   in_fire;
    logic                   out_room;
    logic                   out_load;
    logic [PW-1:0]          prio_clamped;
    logic [SW-1:0]          rd_head, rd_tail, rd_link;
    logic [ATTR_W-1:0]      rd_attrs;
    logic                   align_sel;
    logic [CW-1:0]          rank_plus1;
    logic [CW-1:0]          vis_pos;
    logic                   bucket_end;
    logic                   fill_more;

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign out_room     = !out_valid_reg || out_ready;
    assign prio_clamped = (priority_req > PRIO_MAX8) ? PRIO_LAST : priority_req[PW-1:0];

    assign rd_head  = bkt_rdata_reg[2*SW-1:SW];
    assign rd_tail  = bkt_rdata_reg[SW-1:0];
    assign rd_link  = slot_rdata_reg[SW+ATTR_W-1:ATTR_W];
    assign rd_attrs = slot_rdata_reg[ATTR_W-1:0];

    // Hide-tail mode wins over end alignment.
    assign align_sel  = !hide_tail_mode_reg && align_end_mode_reg;
    assign rank_plus1 = rank_reg + CW'(1);
    assign vis_pos    = align_sel ? (SLOTS_C - used_count_reg + rank_reg) : rank_reg;
    assign bucket_end = (cur_reg == tail_reg) || (rank_plus1 == used_count_reg);
    assign fill_more  = (fill_i_reg < fill_hi_reg);

    always_comb
    begin
        state_next        = state_reg;
        used_count_next   = used_count_reg;
        hide_mark_next    = hide_mark_reg;
        bucket_valid_next = bucket_valid_reg;
        bidx_next         = bidx_reg;
        rank_next         = rank_reg;
        fill_i_next       = fill_i_reg;
        fill_hi_next      = fill_hi_reg;
        no_fill_next      = no_fill_reg;
        cur_next          = cur_reg;
        tail_next         = tail_reg;

        bkt_we       = 1'b0;
        bkt_wdata    = {alloc_s_reg, alloc_s_reg};
        bkt_raddr    = bidx_reg;
        slot_attr_we = 1'b0;
        slot_link_we = 1'b0;
        slot_waddr   = rd_tail;
        slot_wattrs  = sprite_attrs;
        slot_wlink   = alloc_s_reg;
        slot_raddr   = cur_reg;

        out_load      = 1'b0;
        kind_next     = kind_reg;
        accepted_next = accepted_reg;
        slot_next     = slot_reg;
        position_next = position_reg;
        rank_out_next = rank_out_reg;
        attrs_next    = attrs_reg;
        last_next     = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                bkt_raddr = prio_clamped;
                if (in_fire)
                begin
                    if (opcode == OP_ALLOC)
                    begin
                        // The attributes go to the new slot right away; the link
                        // from the old tail follows once the bucket word is read.
                        if (used_count_reg < SLOTS_C)
                        begin
                            slot_attr_we = 1'b1;
                            slot_waddr   = used_count_reg[SW-1:0];
                        end
                        state_next = ST_ALLOC;
                    end
                    else
                    begin
                        bidx_next = '0;
                        rank_next = '0;
                        if (hide_tail_mode_reg)
                        begin
                            // The mark never exceeds the slot count, so no clamp is needed.
                            fill_i_next  = used_count_reg;
                            fill_hi_next = hide_mark_reg;
                            no_fill_next = !(used_count_reg < hide_mark_reg);
                        end
                        else if (align_end_mode_reg)
                        begin
                            fill_i_next    = '0;
                            fill_hi_next   = SLOTS_C - used_count_reg;
                            hide_mark_next = SLOTS_C - used_count_reg;
                            no_fill_next   = (used_count_reg == SLOTS_C);
                        end
                        else
                        begin
                            fill_i_next    = '0;
                            fill_hi_next   = '0;
                            hide_mark_next = '0;
                            no_fill_next   = 1'b1;
                        end
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_ALLOC:
            begin
                bkt_raddr = alloc_p_reg;
                if (out_room)
                begin
                    out_load      = 1'b1;
                    kind_next     = KIND_ALLOC;
                    accepted_next = !alloc_full_reg;
                    slot_next     = alloc_full_reg ? '0 : IDX_W'(alloc_s_reg);
                    position_next = '0;
                    rank_out_next = '0;
                    attrs_next    = alloc_full_reg ? '0 : alloc_attrs_reg;
                    last_next     = 1'b1;
                    if (!alloc_full_reg)
                    begin
                        bkt_we       = 1'b1;
                        bkt_wdata    = {(bucket_valid_reg[alloc_p_reg] ? rd_head : alloc_s_reg),
                                        alloc_s_reg};
                        slot_link_we = bucket_valid_reg[alloc_p_reg];
                        slot_waddr   = rd_tail;
                        bucket_valid_next[alloc_p_reg] = 1'b1;
                        used_count_next = used_count_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (rank_reg == used_count_reg)
                begin
                    state_next = ST_FILL;
                end
                else if (bucket_valid_reg[bidx_reg])
                begin
                    state_next = ST_HEAD;
                end
                else if (bidx_reg == PRIO_LAST)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    bidx_next = bidx_reg + PW'(1);
                end
            end

            ST_HEAD:
            begin
                cur_next   = rd_head;
                tail_next  = rd_tail;
                slot_raddr = rd_head;
                state_next = ST_WALK;
            end

            ST_WALK:
            begin
                // While stalled the same slot is read again, so the data holds.
                if (out_room)
                begin
                    out_load      = 1'b1;
                    kind_next     = KIND_VISIBLE;
                    accepted_next = 1'b0;
                    slot_next     = IDX_W'(cur_reg);
                    position_next = IDX_W'(vis_pos);
                    rank_out_next = IDX_W'(rank_reg);
                    attrs_next    = rd_attrs;
                    last_next     = (rank_plus1 == used_count_reg) && no_fill_reg;
                    rank_next     = rank_plus1;
                    if (bucket_end)
                    begin
                        if (bidx_reg == PRIO_LAST)
                        begin
                            state_next = ST_FILL;
                        end
                        else
                        begin
                            bidx_next  = bidx_reg + PW'(1);
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        cur_next   = rd_link;
                        slot_raddr = rd_link;
                    end
                end
            end

            ST_FILL:
            begin
                if (fill_more)
                begin
                    if (out_room)
                    begin
                        out_load      = 1'b1;
                        kind_next     = KIND_FILLER;
                        accepted_next = 1'b0;
                        slot_next     = '0;
                        position_next = IDX_W'(fill_i_reg);
                        rank_out_next = '0;
                        attrs_next    = FILLER_ATTRS;
                        last_next     = (fill_i_reg + CW'(1) == fill_hi_reg);
                        fill_i_next   = fill_i_reg + CW'(1);
                    end
                end
                else
                begin
                    bucket_valid_next = '0;
                    used_count_next   = '0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            used_count_reg     <= '0;
            hide_mark_reg      <= '0;
            hide_tail_mode_reg <= 1'b0;
            align_end_mode_reg <= 1'b0;
            bucket_valid_reg   <= '0;
            bidx_reg           <= '0;
            rank_reg           <= '0;
            fill_i_reg         <= '0;
            fill_hi_reg        <= '0;
            no_fill_reg        <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            used_count_reg   <= used_count_next;
            hide_mark_reg    <= hide_mark_next;
            bucket_valid_reg <= bucket_valid_next;
            bidx_reg         <= bidx_next;
            rank_reg         <= rank_next;
            fill_i_reg       <= fill_i_next;
            fill_hi_reg      <= fill_hi_next;
            no_fill_reg      <= no_fill_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HIDE_TAIL: hide_tail_mode_reg <= cfg_wdata;
                    REG_ALIGN_END: align_end_mode_reg <= cfg_wdata;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (opcode == OP_ALLOC))
        begin
            alloc_p_reg     <= prio_clamped;
            alloc_s_reg     <= used_count_reg[SW-1:0];
            alloc_full_reg  <= !(used_count_reg < SLOTS_C);
            alloc_attrs_reg <= sprite_attrs;
        end
        cur_reg      <= cur_next;
        tail_reg     <= tail_next;
        kind_reg     <= kind_next;
        accepted_reg <= accepted_next;
        slot_reg     <= slot_next;
        position_reg <= position_next;
        rank_out_reg <= rank_out_next;
        attrs_reg    <= attrs_next;
        last_reg     <= last_next;
    end

    // Bucket memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[alloc_p_reg] <= bkt_wdata;
        end
        bkt_rdata_reg <= bkt_mem[bkt_raddr];
    end

    // Slot memory with separate write enables for the link and attribute fields.
    always_ff @(posedge clk)
    begin
        if (slot_attr_we)
        begin
            slot_mem[slot_waddr][ATTR_W-1:0] <= slot_wattrs;
        end
        if (slot_link_we)
        begin
            slot_mem[slot_waddr][SW+ATTR_W-1:ATTR_W] <= slot_wlink;
        end
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign accepted  = accepted_reg;
    assign slot      = slot_reg;
    assign position  = position_reg;
    assign rank      = rank_out_reg;
    assign attrs_out = attrs_reg;
    assign last      = last_reg;

    `PBSL_ASSERT_IMP(a_load_has_room, clk, rst_n, out_load, out_room)
    `PBSL_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_count_reg <= SLOTS_C)
    `PBSL_ASSERT_IMP(a_walk_rank, clk, rst_n, state_reg == ST_WALK, rank_reg < used_count_reg)
    `PBSL_ASSERT_NXT(a_flush_empties, clk, rst_n, (state_reg == ST_FILL) && !fill_more, (bucket_valid_reg == '0) && (used_count_reg == '0) && (state_reg == ST_IDLE))
    `PBSL_ASSERT_NXT(a_alloc_reply, clk, rst_n, (state_reg == ST_ALLOC) && out_room, out_valid_reg && last_reg && (kind_reg == KIND_ALLOC))

endmodule

`default_nettype wire

>>> dv/tb_priority_bucketed_sprite_list_unit.sv
// ----------------------------------------------------------------------------
// tb_priority_bucketed_sprite_list_unit
// Drives allocate and flush requests into the sprite list unit under every
// mode setting, predicts replies, visible entries and hidden entries, and
// checks each result field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_priority_bucketed_sprite_list_unit;

    import pbsl_pkg::*;

    localparam int SLOTS         = 64;
    localparam int PRIORITIES    = 32;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 30;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 3000;

    typedef struct {
        kind_t              kind;
        bit                 accepted;
        bit [IDX_W-1:0]     slot;
        bit [IDX_W-1:0]     position;
        bit [IDX_W-1:0]     rank;
        bit [ATTR_W-1:0]    attrs;
        bit                 last;
    } sprite_result_t;

    class sprite_list_scoreboard;
        bit [IDX_W-1:0]     bucket_first[PRIORITIES];
        bit [IDX_W-1:0]     bucket_last[PRIORITIES];
        bit                 bucket_live[PRIORITIES];
        bit [IDX_W-1:0]     slot_next[SLOTS];
        bit [ATTR_W-1:0]    slot_data[SLOTS];
        bit [6:0]           used;
        bit [6:0]           hide_mark;
        bit                 hide_mode;
        bit                 align_mode;
        sprite_result_t     results_due[$];
        int                 errors;

        function new();
            used       = 0;
            hide_mark  = 0;
            hide_mode  = 0;
            align_mode = 0;
            errors     = 0;
            foreach (bucket_live[b])
            begin
                bucket_live[b] = 0;
            end
        endfunction

        function void set_mode(logic idx, logic val);
            if (idx == REG_HIDE_TAIL)
            begin
                hide_mode = val;
            end
            else
            begin
                align_mode = val;
            end
        endfunction

        function void add_result(kind_t k, bit acc, int sl, int pos, int rk,
                                 bit [ATTR_W-1:0] at);
            sprite_result_t r;
            r.kind     = k;
            r.accepted = acc;
            r.slot     = IDX_W'(sl);
            r.position = IDX_W'(pos);
            r.rank     = IDX_W'(rk);
            r.attrs    = at;
            r.last     = 0;
            results_due.push_back(r);
        endfunction

        function void note_request(logic op, logic [7:0] prio, logic [ATTR_W-1:0] at);
            int  b;
            int  s;
            int  order;
            int  top;
            int  count_before;
            bit  align_now;
            count_before = results_due.size();
            if (op == OP_ALLOC)
            begin
                b = (prio > PRIORITIES - 1) ? PRIORITIES - 1 : int'(prio);
                if (used >= SLOTS)
                begin
                    add_result(KIND_ALLOC, 0, 0, 0, 0, '0);
                end
                else
                begin
                    s = used;
                    slot_data[s] = at;
                    if (!bucket_live[b])
                    begin
                        bucket_live[b]  = 1;
                        bucket_first[b] = IDX_W'(s);
                    end
                    else
                    begin
                        slot_next[bucket_last[b]] = IDX_W'(s);
                    end
                    bucket_last[b] = IDX_W'(s);
                    used = used + 1;
                    add_result(KIND_ALLOC, 1, s, 0, 0, at);
                end
            end
            else
            begin
                order = 0;
                align_now = !hide_mode && align_mode;
                for (b = 0; b < PRIORITIES; b++)
                begin
                    if (bucket_live[b])
                    begin
                        s = bucket_first[b];
                        while (order < used)
                        begin
                            add_result(KIND_VISIBLE, 0, s,
                                       align_now ? SLOTS - used + order : order,
                                       order, slot_data[s]);
                            order++;
                            if (s == bucket_last[b])
                            begin
                                break;
                            end
                            s = slot_next[s];
                        end
                    end
                end
                if (hide_mode)
                begin
                    // The remembered mark can reach SLOTS; filler never goes past the table.
                    top = (hide_mark > SLOTS) ? SLOTS : int'(hide_mark);
                    for (s = used; s < top; s++)
                    begin
                        add_result(KIND_FILLER, 0, 0, s, 0, FILLER_ATTRS);
                    end
                end
                else if (align_mode)
                begin
                    hide_mark = SLOTS - used;
                    for (s = 0; s < hide_mark; s++)
                    begin
                        add_result(KIND_FILLER, 0, 0, s, 0, FILLER_ATTRS);
                    end
                end
                else
                begin
                    hide_mark = 0;
                end
                used = 0;
                foreach (bucket_live[i])
                begin
                    bucket_live[i] = 0;
                end
            end
            if (results_due.size() > count_before)
            begin
                results_due[results_due.size() - 1].last = 1;
            end
        endfunction

        function void compare_field(string name, logic [ATTR_W-1:0] want,
                                    logic [ATTR_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(kind_t k, logic acc, logic [IDX_W-1:0] sl,
                                   logic [IDX_W-1:0] pos, logic [IDX_W-1:0] rk,
                                   logic [ATTR_W-1:0] at, logic lst);
            sprite_result_t want;
            if (results_due.size() == 0)
            begin
                $error("unexpected result: kind %0d slot %0d position %0d", k, sl, pos);
                errors++;
                return;
            end
            want = results_due.pop_front();
            compare_field("kind", want.kind, k);
            compare_field("accepted", want.accepted, acc);
            compare_field("slot", want.slot, sl);
            compare_field("position", want.position, pos);
            compare_field("rank", want.rank, rk);
            compare_field("attrs_out", want.attrs, at);
            compare_field("last", want.last, lst);
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                opcode       = OP_ALLOC;
    logic [7:0]          priority_req = '0;
    logic [ATTR_W-1:0]   sprite_attrs = '0;
    logic                out_ready    = 1'b0;
    logic                cfg_we       = 1'b0;
    logic                cfg_index    = REG_HIDE_TAIL;
    logic                cfg_wdata    = 1'b0;

    logic                in_ready;
    logic                out_valid;
    kind_t               kind;
    logic                accepted;
    logic [IDX_W-1:0]    slot;
    logic [IDX_W-1:0]    position;
    logic [IDX_W-1:0]    rank;
    logic [ATTR_W-1:0]   attrs_out;
    logic                last;

    sprite_list_scoreboard sb = new();

    int  tx_idle_pct   = 6;
    int  rx_stall_pct  = 78;
    int  items_sent    = 0;
    int  quiet_cycles  = 0;
    bit  hold_pending  = 0;

    priority_bucketed_sprite_list_unit #(
        .SLOTS      (SLOTS),
        .PRIORITIES (PRIORITIES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .priority_req (priority_req),
        .sprite_attrs (sprite_attrs),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .accepted     (accepted),
        .slot         (slot),
        .position     (position),
        .rank         (rank),
        .attrs_out    (attrs_out),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_request(opcode, priority_req, sprite_attrs);
            end
            if (out_valid && out_ready)
            begin
                sb.check_result(kind, accepted, slot, position, rank, attrs_out, last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_priority_bucketed_sprite_list_unit: done, errors");
        $finish;
    end

    // Result side: random stalls, or one long hold-off when the sender asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    function automatic logic [ATTR_W-1:0] random_attrs();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [7:0] random_priority();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'($urandom_range(0, 3));
            2:       return 8'($urandom_range(28, 40));
            default: return 8'($urandom_range(0, PRIORITIES - 1));
        endcase
    endfunction

    task automatic offer_request(input logic op, input logic [7:0] prio,
                                 input logic [ATTR_W-1:0] at);
        if (items_sent < 110)
        begin
            tx_idle_pct  = 6;
            rx_stall_pct = 78;
        end
        else if (items_sent < 220)
        begin
            tx_idle_pct  = 78;
            rx_stall_pct = 6;
        end
        else
        begin
            tx_idle_pct  = 0;
            rx_stall_pct = 0;
        end
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        priority_req <= prio;
        sprite_attrs <= at;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic offer_flush();
        offer_request(OP_FLUSH, random_priority(), random_attrs());
    endtask

    // A flush that emits nothing may still be walking buckets, so allow it to finish.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_modes(input logic hide, input logic align);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_HIDE_TAIL;
        cfg_wdata <= hide;
        @(posedge clk);
        cfg_index <= REG_ALIGN_END;
        cfg_wdata <= align;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_mode(REG_HIDE_TAIL, hide);
        sb.set_mode(REG_ALIGN_END, align);
    endtask

    initial
    begin
        bit   hide_sel[PHASES];
        bit   align_sel[PHASES];
        int   p;
        int   i;
        int   n;
        int   choice;
        int   phase_start;
        bit   first_seq;

        hide_sel  = '{0, 0, 1, 1, 0, 1, 0};
        align_sel = '{0, 1, 0, 1, 1, 0, 0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Plain mode: empty flush, priority extremes and clamping, bucket appends.
        apply_modes(1'b0, 1'b0);
        offer_flush();
        offer_request(OP_ALLOC, 8'd0, '0);
        offer_request(OP_ALLOC, 8'd31, '1);
        offer_request(OP_ALLOC, 8'd32, 48'hAAAA_AAAA_AAAA);
        offer_request(OP_ALLOC, 8'd255, 48'h5555_5555_5555);
        offer_request(OP_ALLOC, 8'd0, random_attrs());
        offer_request(OP_ALLOC, 8'd31, random_attrs());
        offer_flush();

        // End alignment, then an empty flush that hides the whole table.
        apply_modes(1'b0, 1'b1);
        offer_request(OP_ALLOC, 8'd7, random_attrs());
        offer_request(OP_ALLOC, 8'd7, random_attrs());
        offer_request(OP_ALLOC, 8'd0, random_attrs());
        offer_flush();
        offer_flush();

        // Hide-tail wins over alignment; the mark sits at the table size here.
        apply_modes(1'b1, 1'b1);
        offer_request(OP_ALLOC, 8'd3, random_attrs());
        offer_request(OP_ALLOC, 8'd200, random_attrs());
        offer_flush();
        offer_flush();

        // With neither mode set a flush clears the mark, so hide-tail afterward emits no filler.
        apply_modes(1'b0, 1'b0);
        offer_flush();
        apply_modes(1'b1, 1'b0);
        offer_request(OP_ALLOC, 8'd9, random_attrs());
        offer_flush();

        for (p = 0; p < PHASES; p++)
        begin
            apply_modes(hide_sel[p], align_sel[p]);
            if (p == 2)
            begin
                hold_pending = 1;
            end
            phase_start = items_sent;
            first_seq = 1;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                // Long runs can overflow the table so refused allocates show up.
                if (first_seq && (p == 1 || p == 5))
                begin
                    n = $urandom_range(64, 70);
                end
                else
                begin
                    n = $urandom_range(0, 12);
                    if (n > PHASE_ITEMS - (items_sent - phase_start))
                    begin
                        n = PHASE_ITEMS - (items_sent - phase_start);
                    end
                end
                for (i = 0; i < n; i++)
                begin
                    offer_request(OP_ALLOC, random_priority(), random_attrs());
                end
                choice = $urandom_range(0, 99);
                if (choice < 85)
                begin
                    offer_flush();
                end
                else if (choice >= 92)
                begin
                    offer_flush();
                    offer_flush();
                end
                if (p == 3 && first_seq)
                begin
                    wait_for_results();
                end
                first_seq = 0;
            end
        end

        wait_for_results();
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("tb_priority_bucketed_sprite_list_unit: done, clean");
        end
        else
        begin
            $display("tb_priority_bucketed_sprite_list_unit: done, errors");
        end
        $finish;
    end

endmodule
